FILE: rtl/gbn_pkg.sv
// ----------------------------------------------------------------------------
// gbn_pkg
// shared types and constants of the greedy box nms core
// ----------------------------------------------------------------------------
package gbn_pkg;

    // capacity of the kept list (one cell per kept box)
    localparam int MAX_KEPT   = 64;
    localparam int CNT_W      = $clog2(MAX_KEPT + 1);
    localparam int IDX_W      = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;

    localparam int COORD_W    = 16;
    localparam int SLOT_W     = 7;
    localparam int AREA_W     = 32;
    localparam int THR_W      = 16;
    localparam int OV_W       = 16;
    localparam int UNI_W      = AREA_W + 1;
    localparam int PROD_W     = THR_W + UNI_W;

    localparam logic [THR_W-1:0] THR_RESET = 16'd29491;

    // apb port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_IOU_THRESHOLD = 1'b0;

    typedef struct packed {
        logic [COORD_W-1:0] box_left;
        logic [COORD_W-1:0] box_top;
        logic [COORD_W-1:0] box_width;
        logic [COORD_W-1:0] box_height;
        logic               frame_start;
    } t_box_req;

    typedef struct packed {
        logic              keep;
        logic [SLOT_W-1:0] kept_slot;
        logic              list_full;
    } t_res;

    // one stored box with its area
    typedef struct packed {
        logic [COORD_W-1:0] left;
        logic [COORD_W-1:0] top;
        logic [COORD_W-1:0] width;
        logic [COORD_W-1:0] height;
        logic [AREA_W-1:0]  area;
    } t_kept;

    typedef struct packed {
        logic busy;
        logic hit;
    } t_iou_stat;

endpackage

FILE: rtl/gbn_cell.sv
// ----------------------------------------------------------------------------
// gbn_cell
// one slot of the kept-box ring, loads a new box or takes its neighbor's
// ----------------------------------------------------------------------------
module gbn_cell import gbn_pkg::*; (
    input  logic  i_clk,
    input  logic  i_shift,
    input  t_kept i_next,
    input  logic  i_load,
    input  t_kept i_load_data,
    output t_kept o_kept
);

    t_kept r_kept;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_kept <= i_load_data;
        end else if (i_shift) begin
            r_kept <= i_next;
        end
    end

    assign o_kept = r_kept;

endmodule

FILE: rtl/gbn_iou.sv
// ----------------------------------------------------------------------------
// gbn_iou
// pipelined overlap test: intersection * 2^16 > threshold * union
// ----------------------------------------------------------------------------
module gbn_iou import gbn_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  t_kept            i_query,
    input  t_kept            i_ref,
    input  logic [THR_W-1:0] i_thr,
    output t_iou_stat        o_stat
);

    function automatic logic [OV_W-1:0] axis_ov(
        input logic [COORD_W-1:0] a0,
        input logic [COORD_W-1:0] al,
        input logic [COORD_W-1:0] b0,
        input logic [COORD_W-1:0] bl
    );
        logic [COORD_W:0] a1;
        logic [COORD_W:0] b1;
        logic [COORD_W:0] lo;
        logic [COORD_W:0] hi;
        logic [COORD_W:0] diff;
        a1   = (COORD_W+1)'(a0) + (COORD_W+1)'(al);
        b1   = (COORD_W+1)'(b0) + (COORD_W+1)'(bl);
        lo   = (a0 > b0) ? (COORD_W+1)'(a0) : (COORD_W+1)'(b0);
        hi   = (a1 < b1) ? a1 : b1;
        diff = (hi > lo) ? (hi - lo) : '0;
        // overlap never exceeds either length
        return diff[OV_W-1:0];
    endfunction

    logic                r_v1, r_v2, r_v3, r_v4;
    logic [OV_W-1:0]     r_ox, r_oy;
    logic [AREA_W-1:0]   r_area_b1, r_area_b2;
    logic [AREA_W-1:0]   r_inter2, r_inter3, r_inter4;
    logic [UNI_W-1:0]    r_uni3;
    logic [PROD_W-1:0]   r_prod4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        // overlaps per axis
        r_ox      <= axis_ov(i_query.left, i_query.width, i_ref.left, i_ref.width);
        r_oy      <= axis_ov(i_query.top, i_query.height, i_ref.top, i_ref.height);
        r_area_b1 <= i_ref.area;
        // intersection
        r_inter2  <= AREA_W'(r_ox) * AREA_W'(r_oy);
        r_area_b2 <= r_area_b1;
        // union, never negative
        r_uni3    <= UNI_W'(i_query.area) + UNI_W'(r_area_b2) - UNI_W'(r_inter2);
        r_inter3  <= r_inter2;
        // threshold times union
        r_prod4   <= PROD_W'(i_thr) * PROD_W'(r_uni3);
        r_inter4  <= r_inter3;
    end

    assign o_stat.busy = r_v1 | r_v2 | r_v3 | r_v4;
    assign o_stat.hit  = r_v4 && ({1'b0, r_inter4, 16'h0000} > r_prod4);

endmodule

FILE: rtl/greedy_box_nms_core.sv
// ----------------------------------------------------------------------------
// greedy_box_nms_core
// greedy non-maximum suppression of score-sorted boxes by intersection over
// union, kept boxes held in a rotating ring of cells
// ----------------------------------------------------------------------------
//  channel   | handshake                   | payload
//  ----------+-----------------------------+------------------------------
//  box in    | i_box_valid / o_box_ready   | i_box  (t_box_req)
//  result    | o_res_valid / i_res_ready   | o_res  (t_res)
//  config    | psel penable pwrite pready  | paddr pwdata prdata
//
//  one box goes through an accept, a full lap of ring rotations feeding the
//  overlap pipeline one stored box per cycle, a drain of that pipeline and
//  the posting of the result.
//  the ring always turns a full lap so every cell is back in place.
//  reset clears the kept count, the pipeline valid bits and the result valid flag.
//  a stalled result holds in the output register; the next request is taken
//  meanwhile and only waits at its own result stage.
// ----------------------------------------------------------------------------
module greedy_box_nms_core import gbn_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // box requests
    input  logic                  i_box_valid,
    output logic                  o_box_ready,
    input  t_box_req              i_box,
    // results
    output logic                  o_res_valid,
    input  logic                  i_res_ready,
    output t_res                  o_res,
    // apb config port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_RUN   = 4'b0010,
        S_DRAIN = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    t_state             r_state;
    logic [CNT_W-1:0]   r_step;    // ring position of the head cell
    logic [CNT_W-1:0]   r_count;   // stored boxes this frame
    t_kept              r_query;   // box under test with its area
    logic               r_sup;     // sticky suppress flag
    logic [THR_W-1:0]   r_thr;
    logic               r_res_valid;
    t_res               r_res;

    t_kept              w_kept [MAX_KEPT];
    t_iou_stat          w_stat;
    logic               w_accept;
    logic               w_done_go;
    logic               w_full;
    logic               w_store;
    logic               w_cmp_valid;
    logic               w_cfg_wr;

    assign w_accept    = i_box_valid && o_box_ready;
    assign w_done_go   = (r_state == S_DONE) && (!r_res_valid || i_res_ready);
    assign w_full      = (r_count == CNT_W'(MAX_KEPT));
    assign w_store     = w_done_go && !r_sup && !w_full;
    // only slots below the count hold boxes of this frame
    assign w_cmp_valid = (r_state == S_RUN) && (r_step < r_count);

    // ring of kept boxes, head is cell 0, tail wraps to the head
    for (genvar i = 0; i < MAX_KEPT; i++) begin : g_cell
        gbn_cell u_cell (
            .i_clk       (i_clk),
            .i_shift     (r_state == S_RUN),
            .i_next      (w_kept[(i + 1) % MAX_KEPT]),
            .i_load      (w_store && (r_count[IDX_W-1:0] == IDX_W'(i))),
            .i_load_data (r_query),
            .o_kept      (w_kept[i])
        );
    end

    // shared overlap test on the head cell
    gbn_iou u_iou (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_cmp_valid),
        .i_query (r_query),
        .i_ref   (w_kept[0]),
        .i_thr   (r_thr),
        .o_stat  (w_stat)
    );

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
            r_count <= '0;
            r_sup   <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_RUN;
                        r_step  <= '0;
                        r_sup   <= 1'b0;
                        // new frame empties the list
                        if (i_box.frame_start) begin
                            r_count <= '0;
                        end
                    end
                end
                S_RUN: begin
                    if (w_stat.hit) begin
                        r_sup <= 1'b1;
                    end
                    r_step <= r_step + 1'b1;
                    // full lap brings every cell home
                    if (r_step == CNT_W'(MAX_KEPT - 1)) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (w_stat.hit) begin
                        r_sup <= 1'b1;
                    end
                    if (!w_stat.busy) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_done_go) begin
                        r_state <= S_IDLE;
                        if (w_store) begin
                            r_count <= r_count + 1'b1;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // latch the box and its area at accept
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_query.left   <= i_box.box_left;
            r_query.top    <= i_box.box_top;
            r_query.width  <= i_box.box_width;
            r_query.height <= i_box.box_height;
            r_query.area   <= AREA_W'(i_box.box_width) * AREA_W'(i_box.box_height);
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else begin
            if (r_res_valid && i_res_ready) begin
                r_res_valid <= 1'b0;
            end
            if (w_done_go) begin
                r_res_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done_go) begin
            r_res.keep      <= !r_sup;
            // a full list reports the capacity as slot
            r_res.kept_slot <= r_sup ? '0 : SLOT_W'(r_count);
            r_res.list_full <= !r_sup && w_full;
        end
    end

    assign o_box_ready = (r_state == S_IDLE);
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    // config register
    assign w_cfg_wr = psel && penable && pwrite && (paddr[2] == REG_IOU_THRESHOLD);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
        end else if (w_cfg_wr) begin
            r_thr <= pwdata[THR_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_IOU_THRESHOLD) ? APB_DATA_W'(r_thr) : '0;
    assign pready = 1'b1;

endmodule

FILE: rtl/gbn_checker.sv
// ----------------------------------------------------------------------------
// gbn_checker
// port-level checks on the greedy box nms core, bound to the top level
// ----------------------------------------------------------------------------
module gbn_checker import gbn_pkg::*; (
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     i_box_valid,
    input logic     o_box_ready,
    input logic     o_res_valid,
    input logic     i_res_ready,
    input t_res     o_res
);

    // stalled result holds
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !i_res_ready |=> o_res_valid && $stable(o_res))
        else $error("result changed while stalled");

    // suppressed box carries no slot and no full flag
    a_sup_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !o_res.keep |-> (o_res.kept_slot == '0) && !o_res.list_full)
        else $error("suppressed result has slot or full flag");

    // full flag only on a kept box at capacity
    a_full_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_res.list_full |->
            o_res.keep && (o_res.kept_slot == SLOT_W'(MAX_KEPT)))
        else $error("full flag with wrong slot");

    // one box in flight at a time
    a_one_box: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_box_valid && o_box_ready |=> !o_box_ready)
        else $error("second request taken while busy");

endmodule

bind greedy_box_nms_core gbn_checker u_gbn_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_box_valid (i_box_valid),
    .o_box_ready (o_box_ready),
    .o_res_valid (o_res_valid),
    .i_res_ready (i_res_ready),
    .o_res       (o_res)
);

FILE: bench/tb_greedy_box_nms_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_greedy_box_nms_core
// self-checking bench: score-sorted boxes go in over valid/ready, every
// verdict is predicted in the bench from its own kept list and threshold and
// compared field by field, threshold swept over the apb port between phases
// ----------------------------------------------------------------------------
module tb_greedy_box_nms_core;
    import gbn_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int HOLD_CYCLES = 600;
    localparam int DRAIN_CYCLES = 80;
    localparam int MAX_GAP = 18;
    localparam int SPARE_INDEX = 1;
    localparam logic [APB_ADDR_W-1:0] THR_ADDR = APB_ADDR_W'(4 * REG_IOU_THRESHOLD);
    localparam logic [APB_ADDR_W-1:0] SPARE_ADDR = APB_ADDR_W'(4 * SPARE_INDEX);
    localparam int PHASES = 5;
    localparam int PHASE_ITEMS = 55;

    // ------------------------------------------------------------------------
    // verdict predictor and result checker
    // ------------------------------------------------------------------------
    class nms_scoreboard;
        t_box_req    kept_box[MAX_KEPT];
        logic [31:0] kept_area[MAX_KEPT];
        int unsigned kept_total;
        logic [THR_W-1:0] threshold;
        t_res        expected_verdicts[$];
        int unsigned mismatches;

        function new();
            kept_total = 0;
            threshold = THR_RESET;
            mismatches = 0;
        endfunction

        function void set_threshold(logic [THR_W-1:0] value);
            threshold = value;
        endfunction

        function void complain(string msg);
            mismatches++;
            if (mismatches <= 10) begin
                $display("[%0t] mismatch: %s", $time, msg);
            end
        endfunction

        // overlap of two spans, right edges taken without wrap
        function longint unsigned span_overlap(longint unsigned a0, longint unsigned alen,
                                               longint unsigned b0, longint unsigned blen);
            longint unsigned a1, b1, lo, hi;
            a1 = a0 + alen;
            b1 = b0 + blen;
            lo = (a0 > b0) ? a0 : b0;
            hi = (a1 < b1) ? a1 : b1;
            return (hi > lo) ? hi - lo : 64'd0;
        endfunction

        function bit beaten_by(t_box_req b, longint unsigned area, int unsigned slot);
            longint unsigned inter, uni;
            inter = span_overlap(b.box_left, b.box_width,
                                 kept_box[slot].box_left, kept_box[slot].box_width)
                  * span_overlap(b.box_top, b.box_height,
                                 kept_box[slot].box_top, kept_box[slot].box_height);
            uni = area + longint'(kept_area[slot]) - inter;
            return (inter << 16) > longint'(threshold) * uni;
        endfunction

        // accepted request: work out its verdict and update the kept list
        function void note_request(t_box_req b);
            longint unsigned area;
            bit survives;
            t_res v;
            area = longint'(b.box_width) * longint'(b.box_height);
            survives = 1'b1;
            if (b.frame_start) kept_total = 0;
            for (int unsigned i = 0; i < kept_total; i++) begin
                if (beaten_by(b, area, i)) begin
                    survives = 1'b0;
                    break;
                end
            end
            v = '0;
            if (survives) begin
                v.keep = 1'b1;
                if (kept_total < MAX_KEPT) begin
                    kept_box[kept_total] = b;
                    kept_area[kept_total] = area[31:0];
                    v.kept_slot = SLOT_W'(kept_total);
                    kept_total++;
                end else begin
                    v.kept_slot = SLOT_W'(MAX_KEPT);
                    v.list_full = 1'b1;
                end
            end
            expected_verdicts = {expected_verdicts, v};
        endfunction

        function void check_result(t_res got);
            t_res want;
            if (expected_verdicts.size() == 0) begin
                complain($sformatf("result %p with no request pending", got));
                return;
            end
            want = expected_verdicts.pop_front();
            if (got.keep !== want.keep)
                complain($sformatf("keep expected %0d got %0d", want.keep, got.keep));
            if (got.kept_slot !== want.kept_slot)
                complain($sformatf("kept_slot expected %0d got %0d",
                                   want.kept_slot, got.kept_slot));
            if (got.list_full !== want.list_full)
                complain($sformatf("list_full expected %0d got %0d",
                                   want.list_full, got.list_full));
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // signals
    // ------------------------------------------------------------------------
    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_box_valid;
    logic                  o_box_ready;
    t_box_req              i_box;
    logic                  o_res_valid;
    logic                  i_res_ready;
    t_res                  o_res;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    nms_scoreboard sb = new();

    // idling style per side, long receiver hold request
    bit          tx_calm = 1'b0;
    bit          rx_calm = 1'b0;
    logic        hold_go = 1'b0;
    logic        long_hold;
    int          rx_wait = 0;
    int unsigned items_sent = 0;
    int unsigned cycle_count = 0;

    // cluster origin of the current frame and recently sent boxes
    logic [COORD_W-1:0] cluster_x, cluster_y;
    t_box_req           recent[$];

    greedy_box_nms_core u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_box_valid(i_box_valid),
        .o_box_ready(o_box_ready),
        .i_box      (i_box),
        .o_res_valid(o_res_valid),
        .i_res_ready(i_res_ready),
        .o_res      (o_res),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // 10 ns clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // run guard
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("greedy_box_nms_core regression: fail");
            $finish;
        end
    end

    function automatic int draw_gap(bit calm);
        return calm ? 0 : int'($urandom_range(0, MAX_GAP));
    endfunction

    // ------------------------------------------------------------------------
    // result side: check every accepted result, then idle a random stretch
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_res_valid && i_res_ready) begin
            sb.check_result(o_res);
            rx_wait = draw_gap(rx_calm);
        end
        if (long_hold || rx_wait != 0) begin
            i_res_ready <= 1'b0;
            if (!long_hold) rx_wait--;
        end else begin
            i_res_ready <= 1'b1;
        end
    end

    // one long receiver stall, counted here, so the core backs up into its input
    initial begin : rx_long_hold
        long_hold = 1'b0;
        while (!hold_go) @(posedge i_clk);
        long_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        long_hold <= 1'b0;
    end

    // ------------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------------
    // offer one box request after a random gap, return once it is taken;
    // valid is only lowered when a gap follows, so back to back requests
    // see a single assignment per step
    task automatic send_box(t_box_req b);
        int gap;
        gap = draw_gap(tx_calm);
        if (gap > 0) begin
            i_box_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_box_valid <= 1'b1;
        i_box <= b;
        do @(posedge i_clk); while (!o_box_ready);
        sb.note_request(b);
        items_sent++;
        recent = {recent, b};
        if (recent.size() > 12) void'(recent.pop_front());
    endtask

    // drop valid and wait until every verdict is back, core then idle
    task automatic settle();
        i_box_valid <= 1'b0;
        while (sb.expected_verdicts.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // apb write: setup then access, done once pready is seen in access
    task automatic reg_write(logic [APB_ADDR_W-1:0] addr, logic [APB_DATA_W-1:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == THR_ADDR) sb.set_threshold(data[THR_W-1:0]);
    endtask

    // apb read of the threshold, compared with the bench's copy
    task automatic check_threshold();
        logic [APB_DATA_W-1:0] got;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= THR_ADDR;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        got = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        if (got !== APB_DATA_W'(sb.threshold))
            sb.complain($sformatf("threshold read expected %0d got %0d",
                                  sb.threshold, got));
    endtask

    // ------------------------------------------------------------------------
    // box makers
    // ------------------------------------------------------------------------
    function automatic t_box_req make_box(logic [15:0] l, logic [15:0] t, logic [15:0] w,
                                          logic [15:0] h, logic fs);
        t_box_req b;
        b.box_left = l;
        b.box_top = t;
        b.box_width = w;
        b.box_height = h;
        b.frame_start = fs;
        return b;
    endfunction

    // small box near the frame's cluster origin, overlaps are likely
    function automatic t_box_req cluster_box(logic fs);
        return make_box(cluster_x + 16'($urandom_range(0, 1200)),
                        cluster_y + 16'($urandom_range(0, 1200)),
                        16'($urandom_range(16, 1600)), 16'($urandom_range(16, 1600)), fs);
    endfunction

    function automatic t_box_req wild_box(logic fs);
        return make_box(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), fs);
    endfunction

    // slightly moved copy of a recent box
    function automatic t_box_req nudged_box(t_box_req b);
        b.box_left = b.box_left + 16'($urandom_range(0, 64)) - 16'd32;
        b.box_top = b.box_top + 16'($urandom_range(0, 64)) - 16'd32;
        b.box_width = b.box_width + 16'($urandom_range(0, 32)) - 16'd16;
        b.box_height = b.box_height + 16'($urandom_range(0, 32)) - 16'd16;
        b.frame_start = 1'b0;
        return b;
    endfunction

    function automatic t_box_req recent_box();
        if (recent.size() == 0) return cluster_box(1'b0);
        return recent[$urandom_range(0, recent.size() - 1)];
    endfunction

    // ------------------------------------------------------------------------
    // frame shapes
    // ------------------------------------------------------------------------
    // ordinary frame: clustered boxes, near copies, repeats, flat and wild boxes
    task automatic normal_frame();
        int len;
        t_box_req b;
        len = $urandom_range(2, 16);
        cluster_x = 16'($urandom_range(0, 62000));
        cluster_y = 16'($urandom_range(0, 62000));
        for (int i = 0; i < len; i++) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: b = cluster_box(1'b0);
                5, 6: b = nudged_box(recent_box());
                7: begin
                    b = cluster_box(1'b0);
                    if ($urandom_range(0, 1)) b.box_width = '0;
                    else b.box_height = '0;
                end
                8: b = wild_box(1'b0);
                default: b = recent_box();
            endcase
            b.frame_start = (i == 0);
            send_box(b);
        end
    endtask

    // noise: wild boxes and stray frame starts anywhere
    task automatic noise_frame();
        int len;
        t_box_req b;
        len = $urandom_range(1, 6);
        for (int i = 0; i < len; i++) begin
            b = $urandom_range(0, 1) ? wild_box(1'b0) : nudged_box(recent_box());
            b.frame_start = 1'($urandom_range(0, 1));
            send_box(b);
        end
    endtask

    // disjoint tiles, more than the list holds, so the list runs full;
    // a few near copies land on tiles stored and tiles not stored
    task automatic fill_frame();
        int n_tiles;
        t_box_req tiles[$];
        t_box_req b;
        n_tiles = $urandom_range(MAX_KEPT + 1, MAX_KEPT + 8);
        for (int k = 0; k < n_tiles; k++) begin
            b = make_box(16'((k % 10) * 2000 + $urandom_range(0, 200)),
                         16'((k / 10) * 2000 + $urandom_range(0, 200)),
                         16'($urandom_range(0, 1500)), 16'($urandom_range(0, 1500)),
                         k == 0);
            tiles = {tiles, b};
            send_box(b);
            if ($urandom_range(0, 7) == 0)
                send_box(nudged_box(tiles[$urandom_range(0, tiles.size() - 1)]));
        end
        // last tile was never stored, so its copy survives again
        b = tiles[tiles.size() - 1];
        b.frame_start = 1'b0;
        send_box(b);
    endtask

    task automatic random_frames(int unsigned target);
        int unsigned start;
        start = items_sent;
        while (items_sent - start < target) begin
            case ($urandom_range(0, 19))
                0: fill_frame();
                1, 2, 3, 4: noise_frame();
                default: normal_frame();
            endcase
        end
    endtask

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        logic [THR_W-1:0] phase_thr[PHASES];
        i_rst_n = 1'b0;
        i_box_valid = 1'b0;
        i_box = '0;
        i_res_ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        cluster_x = '0;
        cluster_y = '0;
        phase_thr[0] = 16'd32768;
        phase_thr[1] = 16'($urandom);
        phase_thr[2] = THR_RESET;
        phase_thr[3] = 16'd1;
        phase_thr[4] = 16'($urandom);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        check_threshold();

        // directed, threshold at its reset value
        send_box(make_box(16'd0, 16'd0, 16'd0, 16'd0, 1'b1));          // degenerate
        send_box(make_box(16'd0, 16'd0, 16'd0, 16'd0, 1'b0));          // zero union
        send_box(make_box(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0)); // far corner
        send_box(make_box(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0)); // exact repeat
        send_box(make_box(16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 1'b0));    // zero height
        send_box(make_box(16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 1'b0));    // zero width
        send_box(make_box(16'd0, 16'd0, 16'd1600, 16'd1600, 1'b0));
        send_box(make_box(16'd160, 16'd160, 16'd1600, 16'd1600, 1'b0)); // heavy overlap
        send_box(make_box(16'd1000, 16'd0, 16'd1600, 16'd1600, 1'b0)); // light overlap
        send_box(make_box(16'd1600, 16'd0, 16'd1600, 16'd1600, 1'b0)); // edges touch
        send_box(make_box(16'd0, 16'd0, 16'd1600, 16'd1600, 1'b1));    // list cleared
        send_box(make_box(16'd0, 16'd0, 16'd1600, 16'd1600, 1'b0));
        send_box(make_box(16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 1'b1));    // largest area
        send_box(make_box(16'd0, 16'd0, 16'd40000, 16'd40000, 1'b0));
        send_box(make_box(16'd32768, 16'd32768, 16'd32767, 16'd32767, 1'b0));
        settle();

        // write to an unused register must leave the threshold alone
        reg_write(SPARE_ADDR, 32'($urandom));
        check_threshold();

        // threshold zero: any positive overlap suppresses
        reg_write(THR_ADDR, {16'($urandom), 16'd0});
        check_threshold();
        send_box(make_box(16'd0, 16'd0, 16'd1600, 16'd1600, 1'b1));
        send_box(make_box(16'd1599, 16'd1599, 16'd16, 16'd16, 1'b0));
        send_box(make_box(16'd1600, 16'd1600, 16'd16, 16'd16, 1'b0));
        send_box(make_box(16'd100, 16'd100, 16'd0, 16'd50, 1'b0));
        settle();

        // threshold at top: only near-identical boxes suppress
        reg_write(THR_ADDR, {16'($urandom), 16'hFFFF});
        check_threshold();
        send_box(make_box(16'd0, 16'd0, 16'd1600, 16'd1600, 1'b1));
        send_box(make_box(16'd0, 16'd0, 16'd1600, 16'd1600, 1'b0));
        send_box(make_box(16'd0, 16'd0, 16'd1600, 16'd1599, 1'b0));
        settle();

        // random phases, each with its own threshold and idling style
        for (int p = 0; p < PHASES; p++) begin
            reg_write(THR_ADDR, {16'($urandom), phase_thr[p]});
            check_threshold();
            tx_calm = (p == 1) || (p == 3);
            rx_calm = (p == 2) || (p == 3);
            if (p == 1) fill_frame();
            if (p == PHASES - 1) begin
                normal_frame();
                hold_go <= 1'b1;
            end
            random_frames(PHASE_ITEMS);
            settle();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.expected_verdicts.size() != 0)
            sb.complain($sformatf("%0d verdicts never arrived", sb.expected_verdicts.size()));
        if (sb.mismatches == 0) begin
            $display("greedy_box_nms_core regression: pass");
        end else begin
            $display("greedy_box_nms_core regression: fail");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/gbn_pkg.sv
rtl/gbn_cell.sv
rtl/gbn_iou.sv
rtl/greedy_box_nms_core.sv
rtl/gbn_checker.sv
bench/tb_greedy_box_nms_core.sv
